### sv/sate_pkg.sv
// shared constants, types and helper functions for the slider attack table entry block
// used by every stage module and by the top level
package sate_pkg;

    localparam logic [63:0] FILE_A_INNER = 64'h0001010101010100;
    localparam logic [63:0] RANK_1_INNER = 64'h000000000000007E;
    localparam logic [63:0] FILE_A       = 64'h0101010101010101;
    localparam logic [63:0] FILE_H       = 64'h8080808080808080;
    localparam logic [63:0] RANK_1       = 64'h00000000000000FF;
    localparam logic [63:0] RANK_8       = 64'hFF00000000000000;
    localparam logic [63:0] BOARD_EDGES  = FILE_A | FILE_H | RANK_1 | RANK_8;

    localparam int          SUBSET_W     = 12;
    localparam logic        CMD_BISHOP   = 1'b0;
    localparam logic        CMD_ROOK     = 1'b1;

    typedef enum logic [2:0] {
        DIR_N,
        DIR_S,
        DIR_E,
        DIR_W,
        DIR_NE,
        DIR_NW,
        DIR_SE,
        DIR_SW
    } t_dir;

    typedef logic [7:0][3:0] t_rank_off;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'b000, v[k]};
        end
        return c;
    endfunction

    // occluded fill in one direction, then one more step for the attacked squares
    function automatic logic [63:0] ray_attack(input logic [63:0] origin,
                                               input logic [63:0] occ,
                                               input t_dir        dir);
        logic [63:0] gen;
        logic [63:0] pro;
        logic [63:0] keep;
        logic [5:0]  amt;
        logic [5:0]  sh;
        logic        up;
        amt  = 6'd8;
        up   = 1'b1;
        keep = '1;
        case (dir)
            DIR_N:   begin amt = 6'd8; up = 1'b1; keep = '1;      end
            DIR_S:   begin amt = 6'd8; up = 1'b0; keep = '1;      end
            DIR_E:   begin amt = 6'd1; up = 1'b1; keep = ~FILE_A; end
            DIR_W:   begin amt = 6'd1; up = 1'b0; keep = ~FILE_H; end
            DIR_NE:  begin amt = 6'd9; up = 1'b1; keep = ~FILE_A; end
            DIR_NW:  begin amt = 6'd7; up = 1'b1; keep = ~FILE_H; end
            DIR_SE:  begin amt = 6'd7; up = 1'b0; keep = ~FILE_A; end
            DIR_SW:  begin amt = 6'd9; up = 1'b0; keep = ~FILE_H; end
            default: begin amt = 6'd8; up = 1'b1; keep = '1;      end
        endcase
        gen = origin;
        pro = ~occ & keep;
        for (int k = 0; k < 3; k++) begin
            sh  = amt << k;
            gen = gen | (pro & (up ? (gen << sh) : (gen >> sh)));
            pro = pro & (up ? (pro << sh) : (pro >> sh));
        end
        return (up ? (gen << amt) : (gen >> amt)) & keep;
    endfunction

endpackage

### sv/slider_attack_table_entry.sv
// slider attack table entry: top level, chains the four pipeline stages
// depends on sate_pkg, sate_mask, sate_rank, sate_deposit, sate_ray
//
// Input channel (i_valid / o_ready) takes one word per accepted edge: piece
// kind i_cmd (0 bishop, 1 rook), origin i_square and occupancy subset number
// i_subset_index. Output channel (o_valid / i_ready) returns one word per
// input word: attacked squares, relevant-occupancy mask and its bit count.
// Four register stages: mask build, rank counts, bit deposit, ray cast.
// A word accepted at one edge goes through the mask build, rank count, bit
// deposit and ray cast registers to the outputs; one word per cycle sustained
// when the receiver keeps up, set by the per-stage handshake, each stage taking
// a new word whenever it is empty or its downstream neighbor takes the word it
// holds. When the receiver stalls the last stage holds its word and the pipeline
// fills up behind it, so up to four words are in flight before o_ready drops;
// nothing is lost or repeated. Reset (synchronous, active low) clears all stage
// valid bits; the data registers are not reset.
module slider_attack_table_entry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [5:0]  i_square,
    input  logic [11:0] i_subset_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_attack_set,
    output logic [63:0] o_relevant_mask,
    output logic [3:0]  o_relevant_count
);

    logic                s1_valid;
    logic                s1_ready;
    logic                s1_cmd;
    logic [5:0]          s1_square;
    logic [11:0]         s1_subset_index;
    logic [63:0]         s1_mask;

    logic                s2_valid;
    logic                s2_ready;
    logic                s2_cmd;
    logic [5:0]          s2_square;
    logic [11:0]         s2_subset_index;
    logic [63:0]         s2_mask;
    sate_pkg::t_rank_off s2_rank_off;
    logic [3:0]          s2_count;

    logic                s3_valid;
    logic                s3_ready;
    logic                s3_cmd;
    logic [5:0]          s3_square;
    logic [63:0]         s3_mask;
    logic [63:0]         s3_occ;
    logic [3:0]          s3_count;

    sate_mask u_mask (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_square       (i_square),
        .i_subset_index (i_subset_index),
        .o_valid        (s1_valid),
        .i_ready        (s1_ready),
        .o_cmd          (s1_cmd),
        .o_square       (s1_square),
        .o_subset_index (s1_subset_index),
        .o_mask         (s1_mask)
    );

    sate_rank u_rank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .o_ready        (s1_ready),
        .i_cmd          (s1_cmd),
        .i_square       (s1_square),
        .i_subset_index (s1_subset_index),
        .i_mask         (s1_mask),
        .o_valid        (s2_valid),
        .i_ready        (s2_ready),
        .o_cmd          (s2_cmd),
        .o_square       (s2_square),
        .o_subset_index (s2_subset_index),
        .o_mask         (s2_mask),
        .o_rank_off     (s2_rank_off),
        .o_count        (s2_count)
    );

    sate_deposit u_deposit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s2_valid),
        .o_ready        (s2_ready),
        .i_cmd          (s2_cmd),
        .i_square       (s2_square),
        .i_subset_index (s2_subset_index),
        .i_mask         (s2_mask),
        .i_rank_off     (s2_rank_off),
        .i_count        (s2_count),
        .o_valid        (s3_valid),
        .i_ready        (s3_ready),
        .o_cmd          (s3_cmd),
        .o_square       (s3_square),
        .o_mask         (s3_mask),
        .o_occ          (s3_occ),
        .o_count        (s3_count)
    );

    sate_ray u_ray (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s3_valid),
        .o_ready          (s3_ready),
        .i_cmd            (s3_cmd),
        .i_square         (s3_square),
        .i_mask           (s3_mask),
        .i_occ            (s3_occ),
        .i_count          (s3_count),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_attack_set     (o_attack_set),
        .o_relevant_mask  (o_relevant_mask),
        .o_relevant_count (o_relevant_count)
    );

`ifndef ASSERT_OFF
    // carried count agrees with the mask it travels with
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_relevant_mask) == o_relevant_count))
        else $error("relevant count does not match mask");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_relevant_count <= 4'd12))
        else $error("relevant count above twelve");

    // a slider always reaches at least one square
    a_attack_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_attack_set != 64'd0))
        else $error("empty attack set");

    // attacked squares off the edges must lie on the relevant lines
    a_attack_on_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_attack_set & ~o_relevant_mask & ~sate_pkg::BOARD_EDGES) == 64'd0))
        else $error("attack outside relevant lines");

    // occupancy only ever uses mask squares
    a_occ_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_valid |-> ((s3_occ & ~s3_mask) == 64'd0))
        else $error("occupancy outside mask");
`endif

endmodule

### sv/sate_mask.sv
// stage 1: relevant-occupancy mask from piece kind and origin square
// depends on sate_pkg
module sate_mask (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [5:0]  i_square,
    input  logic [11:0] i_subset_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_cmd,
    output logic [5:0]  o_square,
    output logic [11:0] o_subset_index,
    output logic [63:0] o_mask
);

    logic        r_valid;
    logic        r_cmd;
    logic [5:0]  r_square;
    logic [11:0] r_subset_index;
    logic [63:0] r_mask;
    logic [63:0] n_mask;
    logic [63:0] origin;
    logic [63:0] diag;

    assign o_ready = !r_valid || i_ready;
    assign origin  = 64'd1 << i_square;

    always_comb begin
        logic [2:0] rk;
        logic [2:0] fl;
        logic [5:0] bit_sq;
        diag = '0;
        for (int i = 0; i < 64; i++) begin
            bit_sq = i[5:0];
            rk     = bit_sq[5:3];
            fl     = bit_sq[2:0];
            diag[i] = (({1'b0, rk} + {1'b0, i_square[2:0]}) ==
                       ({1'b0, i_square[5:3]} + {1'b0, fl})) ||
                      (({1'b0, rk} + {1'b0, fl}) ==
                       ({1'b0, i_square[5:3]} + {1'b0, i_square[2:0]}));
        end
        if (i_cmd == sate_pkg::CMD_ROOK) begin
            n_mask = ((sate_pkg::FILE_A_INNER << i_square[2:0]) |
                      (sate_pkg::RANK_1_INNER << {i_square[5:3], 3'b000})) & ~origin;
        end else begin
            n_mask = diag & ~origin & ~sate_pkg::BOARD_EDGES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd          <= i_cmd;
            r_square       <= i_square;
            r_subset_index <= i_subset_index;
            r_mask         <= n_mask;
        end
    end

    assign o_valid        = r_valid;
    assign o_cmd          = r_cmd;
    assign o_square       = r_square;
    assign o_subset_index = r_subset_index;
    assign o_mask         = r_mask;

endmodule

### sv/sate_rank.sv
// stage 2: per-rank bit counts of the mask, running rank offsets and total count
// depends on sate_pkg
module sate_rank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic [5:0]          i_square,
    input  logic [11:0]         i_subset_index,
    input  logic [63:0]         i_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_cmd,
    output logic [5:0]          o_square,
    output logic [11:0]         o_subset_index,
    output logic [63:0]         o_mask,
    output sate_pkg::t_rank_off o_rank_off,
    output logic [3:0]          o_count
);

    logic                r_valid;
    logic                r_cmd;
    logic [5:0]          r_square;
    logic [11:0]         r_subset_index;
    logic [63:0]         r_mask;
    sate_pkg::t_rank_off r_rank_off;
    logic [3:0]          r_count;
    sate_pkg::t_rank_off n_rank_off;
    logic [3:0]          n_count;

    assign o_ready = !r_valid || i_ready;

    // offset of a rank is the number of mask bits in all ranks below it
    always_comb begin
        logic [3:0] acc;
        acc = '0;
        for (int r = 0; r < 8; r++) begin
            n_rank_off[r] = acc;
            acc = acc + sate_pkg::popcount8(i_mask[r*8 +: 8]);
        end
        n_count = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd          <= i_cmd;
            r_square       <= i_square;
            r_subset_index <= i_subset_index;
            r_mask         <= i_mask;
            r_rank_off     <= n_rank_off;
            r_count        <= n_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_cmd          = r_cmd;
    assign o_square       = r_square;
    assign o_subset_index = r_subset_index;
    assign o_mask         = r_mask;
    assign o_rank_off     = r_rank_off;
    assign o_count        = r_count;

endmodule

### sv/sate_deposit.sv
// stage 3: deposits the subset number into the mask bits to form the occupancy
// depends on sate_pkg
module sate_deposit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic [5:0]          i_square,
    input  logic [11:0]         i_subset_index,
    input  logic [63:0]         i_mask,
    input  sate_pkg::t_rank_off i_rank_off,
    input  logic [3:0]          i_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_cmd,
    output logic [5:0]          o_square,
    output logic [63:0]         o_mask,
    output logic [63:0]         o_occ,
    output logic [3:0]          o_count
);

    logic        r_valid;
    logic        r_cmd;
    logic [5:0]  r_square;
    logic [63:0] r_mask;
    logic [63:0] r_occ;
    logic [3:0]  r_count;
    logic [63:0] n_occ;

    assign o_ready = !r_valid || i_ready;

    // rank of a mask bit = rank offset plus mask bits below it in the same rank
    always_comb begin
        logic [7:0] row;
        logic [7:0] below;
        logic [4:0] pos;
        logic [5:0] bit_sq;
        n_occ = '0;
        for (int i = 0; i < 64; i++) begin
            bit_sq = i[5:0];
            row    = i_mask[{bit_sq[5:3], 3'b000} +: 8];
            below  = row & ((8'd1 << bit_sq[2:0]) - 8'd1);
            pos    = {1'b0, i_rank_off[bit_sq[5:3]]} +
                     {1'b0, sate_pkg::popcount8(below)};
            n_occ[i] = i_mask[i] && (pos < 5'(sate_pkg::SUBSET_W)) &&
                       i_subset_index[pos[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd    <= i_cmd;
            r_square <= i_square;
            r_mask   <= i_mask;
            r_occ    <= n_occ;
            r_count  <= i_count;
        end
    end

    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;
    assign o_square = r_square;
    assign o_mask   = r_mask;
    assign o_occ    = r_occ;
    assign o_count  = r_count;

endmodule

### sv/sate_ray.sv
// stage 4: casts the four rays against the occupancy, output register of the block
// depends on sate_pkg
module sate_ray (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [5:0]  i_square,
    input  logic [63:0] i_mask,
    input  logic [63:0] i_occ,
    input  logic [3:0]  i_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_attack_set,
    output logic [63:0] o_relevant_mask,
    output logic [3:0]  o_relevant_count
);

    logic        r_valid;
    logic [63:0] r_attack_set;
    logic [63:0] r_relevant_mask;
    logic [3:0]  r_relevant_count;
    logic [63:0] n_attack_set;
    logic [63:0] origin;

    assign o_ready = !r_valid || i_ready;
    assign origin  = 64'd1 << i_square;

    always_comb begin
        if (i_cmd == sate_pkg::CMD_ROOK) begin
            n_attack_set = sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_N) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_S) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_E) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_W);
        end else begin
            n_attack_set = sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_NE) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_NW) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_SE) |
                           sate_pkg::ray_attack(origin, i_occ, sate_pkg::DIR_SW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_attack_set     <= n_attack_set;
            r_relevant_mask  <= i_mask;
            r_relevant_count <= i_count;
        end
    end

    assign o_valid          = r_valid;
    assign o_attack_set     = r_attack_set;
    assign o_relevant_mask  = r_relevant_mask;
    assign o_relevant_count = r_relevant_count;

endmodule

### sim/testbench.sv
// testbench for slider_attack_table_entry: directed and random rook and bishop words
// checked against a behavioral predictor; depends on sate_pkg and the block's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  square;
        logic [11:0] subset;
    } t_query;

    typedef struct packed {
        logic [63:0] attack;
        logic [63:0] mask;
        logic [3:0]  count;
    } t_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_cmd;
    logic [5:0]  i_square;
    logic [11:0] i_subset_index;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_attack_set;
    logic [63:0] o_relevant_mask;
    logic [3:0]  o_relevant_count;

    t_query query_q[$];
    t_entry entry_q[$];
    t_query next_query;
    t_entry want;
    logic   word_taken;
    int     errors;
    int     checked;
    int     rook_words;
    int     bishop_words;
    int     sent;
    int     gap_left;
    int     stall_left;
    bit     pressure_done;

    slider_attack_table_entry dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_square         (i_square),
        .i_subset_index   (i_subset_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_attack_set     (o_attack_set),
        .o_relevant_mask  (o_relevant_mask),
        .o_relevant_count (o_relevant_count)
    );

    // walk from the origin until the board edge or the first occupied square
    function automatic logic [63:0] slide(input logic [5:0] sq, input logic [63:0] occ,
                                          input int dr, input int df);
        logic [63:0] acc;
        int          r;
        int          f;
        bit          blocked;
        acc     = '0;
        blocked = 1'b0;
        r       = sq[5:3];
        f       = sq[2:0];
        r       = r + dr;
        f       = f + df;
        while (r >= 0 && r < 8 && f >= 0 && f < 8 && !blocked) begin
            acc[r * 8 + f] = 1'b1;
            blocked        = occ[r * 8 + f];
            r              = r + dr;
            f              = f + df;
        end
        return acc;
    endfunction

    function automatic t_entry table_entry_of(input t_query q);
        t_entry      e;
        logic [63:0] origin;
        logic [63:0] occ;
        int          k;
        origin = 64'd1 << q.square;
        if (q.cmd == sate_pkg::CMD_ROOK) begin
            e.mask = ((sate_pkg::FILE_A_INNER << q.square[2:0]) |
                      (sate_pkg::RANK_1_INNER << {q.square[5:3], 3'b000})) & ~origin;
        end else begin
            e.mask = (slide(q.square, '0, 1, 1) | slide(q.square, '0, -1, 1) |
                      slide(q.square, '0, 1, -1) | slide(q.square, '0, -1, -1)) &
                     ~sate_pkg::BOARD_EDGES;
        end
        // subset bits land on the mask bits from the bottom up
        occ = '0;
        k   = 0;
        for (int b = 0; b < 64; b++) begin
            if (e.mask[b]) begin
                if (k < 12 && q.subset[k]) begin
                    occ[b] = 1'b1;
                end
                k = k + 1;
            end
        end
        e.count = 4'($countones(e.mask));
        if (q.cmd == sate_pkg::CMD_ROOK) begin
            e.attack = slide(q.square, occ, 1, 0) | slide(q.square, occ, -1, 0) |
                       slide(q.square, occ, 0, 1) | slide(q.square, occ, 0, -1);
        end else begin
            e.attack = slide(q.square, occ, 1, 1) | slide(q.square, occ, -1, 1) |
                       slide(q.square, occ, 1, -1) | slide(q.square, occ, -1, -1);
        end
        return e;
    endfunction

    // mostly short idle spans, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !word_taken) begin
            // hold the word until it is taken
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left = gap_left - 1;
        end else if (query_q.size() > 0) begin
            next_query     = query_q.pop_front();
            i_valid        <= 1'b1;
            i_cmd          <= next_query.cmd;
            i_square       <= next_query.square;
            i_subset_index <= next_query.subset;
            // every fourth stretch of words goes back to back
            gap_left = ((sent / 80) % 4 == 3) ? 0 : idle_span();
            sent     = sent + 1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!pressure_done && checked >= 200) begin
            // long hold-off so the pipeline backs up into the sender
            pressure_done = 1'b1;
            stall_left    = 79;
            i_ready       <= 1'b0;
        end else if ((checked / 80) % 4 == 1) begin
            i_ready <= 1'b1;
        end else begin
            stall_left = idle_span();
            i_ready    <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
        end
    end

    // predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            entry_q.push_back(table_entry_of(t_query'({i_cmd, i_square, i_subset_index})));
            if (i_cmd == sate_pkg::CMD_ROOK) begin
                rook_words = rook_words + 1;
            end else begin
                bishop_words = bishop_words + 1;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (entry_q.size() == 0) begin
                $error("result word with nothing expected");
                errors = errors + 1;
            end else begin
                want    = entry_q.pop_front();
                checked = checked + 1;
                if (o_attack_set !== want.attack) begin
                    $error("attack_set: expected %h, got %h", want.attack, o_attack_set);
                    errors = errors + 1;
                end
                if (o_relevant_mask !== want.mask) begin
                    $error("relevant_mask: expected %h, got %h", want.mask, o_relevant_mask);
                    errors = errors + 1;
                end
                if (o_relevant_count !== want.count) begin
                    $error("relevant_count: expected %0d, got %0d", want.count,
                           o_relevant_count);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int     probe_sq[6];
        t_query q;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_cmd          = 1'b0;
        i_square       = '0;
        i_subset_index = '0;
        word_taken     = 1'b0;
        errors         = 0;
        checked        = 0;
        rook_words     = 0;
        bishop_words   = 0;
        sent           = 0;
        gap_left       = 0;
        stall_left     = 0;
        pressure_done  = 1'b0;

        // corners, a center square and an edge square, empty and full subsets;
        // a full subset also carries bits past the mask count
        probe_sq = '{0, 7, 56, 63, 27, 32};
        foreach (probe_sq[s]) begin
            q.square = 6'(probe_sq[s]);
            q.cmd    = sate_pkg::CMD_BISHOP;
            q.subset = '0;
            query_q.push_back(q);
            q.subset = '1;
            query_q.push_back(q);
            q.cmd    = sate_pkg::CMD_ROOK;
            q.subset = '0;
            query_q.push_back(q);
            q.subset = '1;
            query_q.push_back(q);
        end
        for (int n = 0; n < 700; n++) begin
            q.cmd    = 1'($urandom_range(0, 1));
            q.square = 6'($urandom_range(0, 63));
            // sparse subsets give long rays
            q.subset = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 63))
                                                   : 12'($urandom_range(0, 4095));
            query_q.push_back(q);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (query_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (entry_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d rook and %0d bishop words, %0d results checked",
                 rook_words, bishop_words, checked);
        $display("%0d field mismatches or unexpected results", errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
